>>> design/cpwsc_pkg.sv
// Shared types and constants for the contact pair warm start cache.
package cpwsc_pkg;

  localparam logic [1:0]  REQ_POINT  = 2'd0;
  localparam logic [1:0]  REQ_FRAME  = 2'd1;
  localparam logic [1:0]  REQ_CLEAR  = 2'd2;
  localparam logic [31:0] NO_FEATURE = 32'hFFFF_FFFF;
  localparam int          ID_SHIFT   = 32;
  localparam logic [6:0]  EVICT_MAX  = 7'd127;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] body_a;
    logic [31:0] body_b;
    logic        has_point;
    logic [31:0] feature_id;
    logic [31:0] normal_impulse;
    logic [31:0] tangent_impulse_one;
    logic [31:0] tangent_impulse_two;
    logic        last_point;
  } in_t;

  typedef struct packed {
    logic [31:0] out_normal;
    logic [31:0] out_tangent_one;
    logic [31:0] out_tangent_two;
    logic        warm_started;
    logic        new_pair;
    logic        table_full;
    logic        last_result;
    logic [6:0]  evicted_count;
  } out_t;

  typedef struct packed {
    logic [31:0] feat;
    logic [31:0] normal;
    logic [31:0] tan_one;
    logic [31:0] tan_two;
  } point_t;

  // Commands broadcast to every cell of the pair table.
  typedef struct packed {
    logic snap;
    logic shift;
    logic clear;
    logic evict;
    logic wr_key;
    logic set_used;
  } cell_ctl_t;

  // Status flags that ride the shift chain toward the head cell.
  typedef struct packed {
    logic hit;
    logic free;
    logic stale;
  } cell_flag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SNAP,
    ST_SCAN,
    ST_PLACE,
    ST_CNT,
    ST_DEC,
    ST_LRD,
    ST_LCMP,
    ST_FIN,
    ST_COMMIT,
    ST_EVICT,
    ST_CLEAR,
    ST_NOP
  } state_e;

endpackage

>>> design/cpwsc_cell.sv
// One pair table entry: valid and touched marks, the pair key and a flag shift stage.
module cpwsc_cell #(
  parameter int SW  = 6,
  parameter int IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cpwsc_pkg::cell_ctl_t   ctl_i,
  input  logic [SW-1:0]          slot_i,
  input  logic [63:0]            probe_i,
  input  cpwsc_pkg::cell_flag_t  flag_i,
  output cpwsc_pkg::cell_flag_t  flag_o
);

  logic                  valid_q, touched_q;
  logic [63:0]           key_q;
  cpwsc_pkg::cell_flag_t sh_q, sh_d;
  logic                  sel;

  assign sel = (slot_i == SW'(IDX));

  always_comb begin
    sh_d = sh_q;
    if (ctl_i.snap) begin
      sh_d.hit   = valid_q && (key_q == probe_i);
      sh_d.free  = !valid_q;
      sh_d.stale = valid_q && !touched_q;
    end else if (ctl_i.shift) begin
      sh_d = flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      touched_q <= 1'b0;
      sh_q      <= '0;
    end else begin
      sh_q <= sh_d;
      if (ctl_i.clear) begin
        valid_q   <= 1'b0;
        touched_q <= 1'b0;
      end else if (ctl_i.evict) begin
        valid_q   <= valid_q && touched_q;
        touched_q <= 1'b0;
      end else if (ctl_i.set_used && sel) begin
        valid_q   <= 1'b1;
        touched_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_key && sel) begin
      key_q <= probe_i;
    end
  end

  assign flag_o = sh_q;

endmodule

>>> design/contact_pair_warm_start_cache.sv
// Top level of the contact pair warm start cache: sequencer, point store and cell row.
//
// One input channel (start / busy) and one result channel (res_valid_o / res_o).
// A beat is taken when start is high and busy is low; every beat yields exactly
// one result beat, shown for a single cycle with res_valid_o high. The receiver
// cannot stall, so a result is never held.
// The pair table is a row of TABLE_ENTRIES cells. A lookup snapshots all cells in the same
// cycle and shifts their flags to the head, one cell a cycle. An end-of-frame beat passes
// through SNAP, SCAN and EVICT, and the first point of a manifold spends SNAP and SCAN on
// the scan and PLACE on the placement. A point then reads the stored point count (CNT and
// DEC), walks the stored points (LRD and LCMP for each) and forms its result in FIN.
// Later points skip the scan. Unless the table was full when the manifold opened, its last
// point writes the staged points, one a cycle, and then the count in COMMIT. A clear or an
// unknown request passes only through its CLEAR or NOP state. The result strobe is
// registered and appears in the cycle after the last busy cycle, while busy is already
// low. A new beat is taken only while busy is low, so never while the last is in work.
// Reset empties the table and closes any open manifold at once; the pair keys
// and point memory keep whatever they held and are never read before written.
module contact_pair_warm_start_cache #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_POINTS    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cpwsc_pkg::in_t   req_i,
  output logic             res_valid_o,
  output cpwsc_pkg::out_t  res_o
);

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PM_DEPTH = TABLE_ENTRIES * (2 ** PW);

  cpwsc_pkg::state_e state_q, state_d;
  cpwsc_pkg::in_t    in_q;
  cpwsc_pkg::out_t   res_q;
  cpwsc_pkg::cell_ctl_t ctl;
  cpwsc_pkg::cell_flag_t flag_w [TABLE_ENTRIES+1];
  cpwsc_pkg::point_t stage_q [MAX_POINTS];
  cpwsc_pkg::point_t pm [PM_DEPTH];
  cpwsc_pkg::point_t pm_rd_q, hit_pt_q, new_pt;
  logic [CW-1:0]     cnt_mem [TABLE_ENTRIES];
  logic [CW-1:0]     cnt_rd_q;

  logic           open_q, new_q, full_q, warm_q, first_q;
  logic           found_q, free_found_q;
  logic [SW-1:0]  slot_q, free_slot_q, scan_q;
  logic [CW-1:0]  pidx_q, j_q;
  logic [6:0]     ev_cnt_q;
  logic           strobe_q, strobe_d;
  logic [63:0]    probe;
  logic [31:0]    id_lo, id_hi;
  logic           accept, scan_last, need_look, pm_we;
  logic [SW+PW-1:0] pm_addr;

  assign accept    = start && !busy;
  assign busy      = (state_q != cpwsc_pkg::ST_IDLE);
  assign scan_last = (scan_q == SW'(TABLE_ENTRIES - 1));
  assign id_lo     = (in_q.body_a < in_q.body_b) ? in_q.body_a : in_q.body_b;
  assign id_hi     = (in_q.body_a < in_q.body_b) ? in_q.body_b : in_q.body_a;
  assign probe     = {id_lo, id_hi};
  assign pm_addr   = {slot_q, j_q[PW-1:0]};
  assign need_look = in_q.has_point && !new_q && (in_q.feature_id != cpwsc_pkg::NO_FEATURE)
                     && (cnt_rd_q != '0);
  assign pm_we     = (state_q == cpwsc_pkg::ST_COMMIT) && (j_q < pidx_q);

  // Point as seen after warm start.
  always_comb begin
    new_pt.feat    = in_q.feature_id;
    new_pt.normal  = warm_q ? hit_pt_q.normal  : in_q.normal_impulse;
    new_pt.tan_one = warm_q ? hit_pt_q.tan_one : in_q.tangent_impulse_one;
    new_pt.tan_two = warm_q ? hit_pt_q.tan_two : in_q.tangent_impulse_two;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpwsc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            cpwsc_pkg::REQ_POINT: state_d = open_q ? cpwsc_pkg::ST_CNT : cpwsc_pkg::ST_SNAP;
            cpwsc_pkg::REQ_FRAME: state_d = cpwsc_pkg::ST_SNAP;
            cpwsc_pkg::REQ_CLEAR: state_d = cpwsc_pkg::ST_CLEAR;
            default:              state_d = cpwsc_pkg::ST_NOP;
          endcase
        end
      end
      cpwsc_pkg::ST_SNAP: state_d = cpwsc_pkg::ST_SCAN;
      cpwsc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = (in_q.req_type == cpwsc_pkg::REQ_POINT) ? cpwsc_pkg::ST_PLACE
                                                           : cpwsc_pkg::ST_EVICT;
        end
      end
      cpwsc_pkg::ST_PLACE: state_d = cpwsc_pkg::ST_CNT;
      cpwsc_pkg::ST_CNT:   state_d = cpwsc_pkg::ST_DEC;
      cpwsc_pkg::ST_DEC:   state_d = need_look ? cpwsc_pkg::ST_LRD : cpwsc_pkg::ST_FIN;
      cpwsc_pkg::ST_LRD:   state_d = cpwsc_pkg::ST_LCMP;
      cpwsc_pkg::ST_LCMP: begin
        if (pm_rd_q.feat == in_q.feature_id || (j_q + 1'b1) == cnt_rd_q) begin
          state_d = cpwsc_pkg::ST_FIN;
        end else begin
          state_d = cpwsc_pkg::ST_LRD;
        end
      end
      cpwsc_pkg::ST_FIN: begin
        state_d = (in_q.last_point && !full_q) ? cpwsc_pkg::ST_COMMIT : cpwsc_pkg::ST_IDLE;
      end
      cpwsc_pkg::ST_COMMIT: state_d = (j_q < pidx_q) ? cpwsc_pkg::ST_COMMIT
                                                     : cpwsc_pkg::ST_IDLE;
      cpwsc_pkg::ST_EVICT: state_d = cpwsc_pkg::ST_IDLE;
      cpwsc_pkg::ST_CLEAR: state_d = cpwsc_pkg::ST_IDLE;
      cpwsc_pkg::ST_NOP:   state_d = cpwsc_pkg::ST_IDLE;
      default:             state_d = cpwsc_pkg::ST_IDLE;
    endcase
  end

  // Cell commands and result strobe.
  always_comb begin
    ctl      = '0;
    strobe_d = 1'b0;
    unique case (state_q)
      cpwsc_pkg::ST_SNAP:   ctl.snap = 1'b1;
      cpwsc_pkg::ST_SCAN:   ctl.shift = 1'b1;
      // The key is taken only from the beat that opened the manifold.
      cpwsc_pkg::ST_CNT:    ctl.wr_key = first_q && new_q && !full_q;
      cpwsc_pkg::ST_FIN:    strobe_d = !(in_q.last_point && !full_q);
      cpwsc_pkg::ST_COMMIT: begin
        ctl.set_used = !(j_q < pidx_q);
        strobe_d     = !(j_q < pidx_q);
      end
      cpwsc_pkg::ST_EVICT: begin
        ctl.evict = 1'b1;
        strobe_d  = 1'b1;
      end
      cpwsc_pkg::ST_CLEAR: begin
        ctl.clear = 1'b1;
        strobe_d  = 1'b1;
      end
      cpwsc_pkg::ST_NOP:   strobe_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cpwsc_pkg::ST_IDLE;
      strobe_q     <= 1'b0;
      open_q       <= 1'b0;
      new_q        <= 1'b0;
      full_q       <= 1'b0;
      first_q      <= 1'b0;
      pidx_q       <= '0;
      slot_q       <= '0;
      free_slot_q  <= '0;
      scan_q       <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      ev_cnt_q     <= '0;
      j_q          <= '0;
      warm_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      unique case (state_q)
        cpwsc_pkg::ST_SNAP: begin
          scan_q       <= '0;
          found_q      <= 1'b0;
          free_found_q <= 1'b0;
          ev_cnt_q     <= '0;
        end
        cpwsc_pkg::ST_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (flag_w[0].hit && !found_q) begin
            found_q <= 1'b1;
            slot_q  <= scan_q;
          end
          if (flag_w[0].free && !free_found_q) begin
            free_found_q <= 1'b1;
            free_slot_q  <= scan_q;
          end
          if (flag_w[0].stale && ev_cnt_q != cpwsc_pkg::EVICT_MAX) begin
            ev_cnt_q <= ev_cnt_q + 1'b1;
          end
        end
        cpwsc_pkg::ST_PLACE: begin
          new_q  <= !found_q;
          full_q <= !found_q && !free_found_q;
          if (!found_q) begin
            slot_q <= free_found_q ? free_slot_q : '0;
          end
          open_q  <= 1'b1;
          first_q <= 1'b1;
          pidx_q  <= '0;
        end
        cpwsc_pkg::ST_CNT: begin
          first_q <= 1'b0;
        end
        cpwsc_pkg::ST_DEC: begin
          warm_q <= 1'b0;
          j_q    <= '0;
        end
        cpwsc_pkg::ST_LCMP: begin
          if (pm_rd_q.feat == in_q.feature_id) begin
            warm_q <= 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        cpwsc_pkg::ST_FIN: begin
          j_q <= '0;
          if (in_q.has_point && !full_q && pidx_q < CW'(MAX_POINTS)) begin
            pidx_q <= pidx_q + 1'b1;
          end
          if (in_q.last_point && full_q) begin
            open_q <= 1'b0;
            pidx_q <= '0;
          end
        end
        cpwsc_pkg::ST_COMMIT: begin
          if (j_q < pidx_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            open_q <= 1'b0;
            pidx_q <= '0;
          end
        end
        cpwsc_pkg::ST_EVICT, cpwsc_pkg::ST_CLEAR: begin
          open_q <= 1'b0;
          pidx_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i;
    end
    if (state_q == cpwsc_pkg::ST_LCMP) begin
      hit_pt_q <= pm_rd_q;
    end
    if (state_q == cpwsc_pkg::ST_FIN && in_q.has_point && !full_q
        && pidx_q < CW'(MAX_POINTS)) begin
      stage_q[pidx_q[PW-1:0]] <= new_pt;
    end
    unique case (state_q)
      cpwsc_pkg::ST_FIN: begin
        res_q <= '{out_normal:      in_q.has_point ? new_pt.normal  : 32'h0,
                   out_tangent_one: in_q.has_point ? new_pt.tan_one : 32'h0,
                   out_tangent_two: in_q.has_point ? new_pt.tan_two : 32'h0,
                   warm_started:    in_q.has_point && warm_q,
                   new_pair:        new_q,
                   table_full:      full_q,
                   last_result:     in_q.last_point,
                   evicted_count:   7'h0};
      end
      cpwsc_pkg::ST_EVICT: begin
        res_q <= '{evicted_count: ev_cnt_q, default: '0};
      end
      cpwsc_pkg::ST_CLEAR, cpwsc_pkg::ST_NOP: res_q <= '0;
      default: ;
    endcase
  end

  // Stored point memory, one port.
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pm[pm_addr] <= stage_q[j_q[PW-1:0]];
    end
    pm_rd_q <= pm[pm_addr];
  end

  // Stored point count per pair.
  always_ff @(posedge clk_i) begin
    if (ctl.set_used) begin
      cnt_mem[slot_q] <= pidx_q;
    end
    cnt_rd_q <= cnt_mem[slot_q];
  end

  assign flag_w[TABLE_ENTRIES] = '0;

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    cpwsc_cell #(
      .SW  (SW),
      .IDX (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .slot_i  (slot_q),
      .probe_i (probe),
      .flag_i  (flag_w[gi+1]),
      .flag_o  (flag_w[gi])
    );
  end

  assign res_valid_o = strobe_q;
  assign res_o       = res_q;

  a_strobe_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without preceding work");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_pidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pidx_q <= CW'(MAX_POINTS))
    else $error("staged point count beyond capacity");

  a_full_is_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && full_q) |-> new_q)
    else $error("full table flagged for a known pair");

endmodule
